@@ rtl/hmap_pkg.sv @@
// Shared types and constants for the chained integer-key hash map.
// Used by hmap_front, hmap_back and chained_int_key_hash_map_top.
package hmap_pkg;

    // Field widths fixed by the interface.
    localparam int OP_W   = 2;
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 4;
    localparam int STAT_W = 2;

    // Smallest bucket count log2 that the mask honors.
    localparam logic [CFG_W-1:0] MIN_LOG2 = 4'd3;

    // Operation codes as they arrive on the input word.
    localparam logic [OP_W-1:0] OPC_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OPC_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OPC_REMOVE = 2'd2;
    // Unassigned code; it behaves as a find.
    localparam logic [OP_W-1:0] OPC_SPARE  = 2'd3;

    // Classified operation carried to the back end.
    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } t_status;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_HEAD,
        ST_NODE,
        ST_EXEC,
        ST_ALLOC,
        ST_FREE,
        ST_RESULT
    } t_state;

    // Handshake between the request queue and the back end.
    typedef struct packed {
        logic pop;
        logic init_done;
    } t_back_ctl;

endpackage

@@ rtl/hmap_front.sv @@
// Front end of the hash map: accepts words, classifies the operation,
// computes the bucket index and queues requests. Depends on hmap_pkg.
module hmap_front #(
    parameter int BKT_W = 8,
    parameter int VW    = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [hmap_pkg::OP_W-1:0]  i_operation,
    input  logic [hmap_pkg::KEY_W-1:0] i_key,
    input  logic [VW-1:0]              i_value_in,
    input  logic [hmap_pkg::CFG_W-1:0] i_log2,
    input  hmap_pkg::t_back_ctl        i_back,
    output logic                       o_q_valid,
    output hmap_pkg::t_op              o_q_op,
    output logic [hmap_pkg::KEY_W-1:0] o_q_key,
    output logic [VW-1:0]              o_q_val,
    output logic [BKT_W-1:0]           o_q_bkt
);
    import hmap_pkg::*;

    localparam int QD = 2;

    t_op                  op_cls;
    logic [CFG_W-1:0]     lg;
    logic [BKT_W-1:0]     bkt;
    logic                 push;

    t_op                  r_op  [QD];
    logic [KEY_W-1:0]     r_key [QD];
    logic [VW-1:0]        r_val [QD];
    logic [BKT_W-1:0]     r_bkt [QD];
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;

    // Decode the operation; the unused code behaves as a find.
    always_comb begin
        unique case (i_operation)
            OPC_INSERT: op_cls = OP_INSERT;
            OPC_REMOVE: op_cls = OP_REMOVE;
            default:    op_cls = OP_FIND;
        endcase
    end

    // Bucket mask: max(log2, 3) low key bits, saturating at the bucket width.
    always_comb begin
        lg = (i_log2 < MIN_LOG2) ? MIN_LOG2 : i_log2;
        for (int j = 0; j < BKT_W; j++) begin
            bkt[j] = i_key[j] & (32'(j) < 32'(lg));
        end
    end

    // Items are taken only once the back end has finished its clearing pass.
    assign o_ready = i_back.init_done && (r_cnt != 2'(QD));
    assign push    = i_valid && o_ready;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_op[r_wp]  <= op_cls;
            r_key[r_wp] <= i_key;
            r_val[r_wp] <= i_value_in;
            r_bkt[r_wp] <= bkt;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_back.pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_back.pop);
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_op    = r_op[r_rp];
    assign o_q_key   = r_key[r_rp];
    assign o_q_val   = r_val[r_rp];
    assign o_q_bkt   = r_bkt[r_rp];

endmodule

@@ rtl/hmap_back.sv @@
// Back end of the hash map: bucket heads, node pool and free list, walked
// one node per memory read by a sequencer. Depends on hmap_pkg.
module hmap_back #(
    parameter int MAX_BUCKETS = 256,
    parameter int NODE_POOL   = 1024,
    parameter int BKT_W       = 8,
    parameter int PTR_W       = 11,
    parameter int VW          = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  hmap_pkg::t_op               i_q_op,
    input  logic [hmap_pkg::KEY_W-1:0]  i_q_key,
    input  logic [VW-1:0]               i_q_val,
    input  logic [BKT_W-1:0]            i_q_bkt,
    output hmap_pkg::t_back_ctl         o_back,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hmap_pkg::STAT_W-1:0] o_status,
    output logic [hmap_pkg::DATA_W-1:0] o_value_out,
    output logic [PTR_W-1:0]            o_entry_count
);
    import hmap_pkg::*;

    localparam int NODE_W  = PTR_W - 1;
    localparam int SWEEP_N = (MAX_BUCKETS > NODE_POOL) ? MAX_BUCKETS : NODE_POOL;
    localparam int SW_W    = $clog2(SWEEP_N);
    localparam logic [PTR_W-1:0] NIL  = PTR_W'(NODE_POOL);
    localparam logic [SW_W:0]    MB_L = (SW_W + 1)'(MAX_BUCKETS);
    localparam logic [SW_W:0]    NP_L = (SW_W + 1)'(NODE_POOL);
    localparam logic [SW_W-1:0]  SW_LAST = SW_W'(SWEEP_N - 1);

    // Memories.
    logic [PTR_W-1:0] head_mem [MAX_BUCKETS];
    logic [KEY_W-1:0] key_mem  [NODE_POOL];
    logic [VW-1:0]    val_mem  [NODE_POOL];
    logic [PTR_W-1:0] link_mem [NODE_POOL];

    t_state r_state, n_state;

    // Request and walk registers.
    t_op               r_op;
    logic [KEY_W-1:0]  r_key;
    logic [VW-1:0]     r_val;
    logic [BKT_W-1:0]  r_bkt;
    logic [PTR_W-1:0]  r_head, r_cur, r_prev, r_flink;
    logic [VW-1:0]     r_fval;
    logic [PTR_W-1:0]  r_free_head;
    logic [PTR_W-1:0]  r_count;
    logic [SW_W-1:0]   r_sweep;
    logic              r_init_done;
    t_status           r_res_status;
    logic [VW-1:0]     r_res_value;

    // Registered memory read data.
    logic [PTR_W-1:0]  r_head_q;
    logic [KEY_W-1:0]  r_key_q;
    logic [VW-1:0]     r_val_q;
    logic [PTR_W-1:0]  r_link_q;

    // Output register.
    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_value;
    logic [PTR_W-1:0]  r_out_count;

    // Memory controls.
    logic              head_rd, node_rd;
    logic [BKT_W-1:0]  head_rd_addr;
    logic [PTR_W-1:0]  node_rd_addr;
    logic              head_we, link_we, key_we, val_we;
    logic [BKT_W-1:0]  head_wa;
    logic [PTR_W-1:0]  head_wd, link_wa, link_wd, kv_wa;
    logic [VW-1:0]     val_wd;

    logic              pop, out_load, found, key_hit, sweep_end;

    assign found     = (r_cur != NIL);
    assign key_hit   = (r_key_q == r_key);
    assign sweep_end = (r_sweep == SW_LAST);
    assign out_load  = (r_state == ST_RESULT) && (!r_out_valid || i_ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT:   if (sweep_end) n_state = ST_IDLE;
            ST_IDLE:   if (i_q_valid) n_state = ST_HEAD;
            ST_HEAD:   n_state = (r_head_q == NIL) ? ST_EXEC : ST_NODE;
            ST_NODE:   if (key_hit || r_link_q == NIL) n_state = ST_EXEC;
            ST_EXEC: begin
                unique case (r_op)
                    OP_INSERT: n_state = (!found && r_free_head != NIL) ? ST_ALLOC
                                                                          : ST_RESULT;
                    OP_REMOVE: n_state = found ? ST_FREE : ST_RESULT;
                    default:   n_state = ST_RESULT;
                endcase
            end
            ST_ALLOC:  n_state = ST_RESULT;
            ST_FREE:   n_state = ST_RESULT;
            ST_RESULT: if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_INIT;
        endcase
    end

    // Memory controls per state.
    always_comb begin
        pop          = 1'b0;
        head_rd      = 1'b0;
        head_rd_addr = i_q_bkt;
        node_rd      = 1'b0;
        node_rd_addr = r_link_q;
        head_we      = 1'b0;
        head_wa      = r_bkt;
        head_wd      = r_flink;
        link_we      = 1'b0;
        link_wa      = r_prev;
        link_wd      = r_flink;
        key_we       = 1'b0;
        val_we       = 1'b0;
        kv_wa        = r_cur;
        val_wd       = r_val;
        unique case (r_state)
            ST_INIT: begin
                head_we = ({1'b0, r_sweep} < MB_L);
                head_wa = BKT_W'(r_sweep);
                head_wd = NIL;
                link_we = ({1'b0, r_sweep} < NP_L);
                link_wa = PTR_W'(r_sweep);
                link_wd = PTR_W'(r_sweep) + PTR_W'(1);
            end
            ST_IDLE: begin
                pop     = i_q_valid;
                head_rd = i_q_valid;
            end
            ST_HEAD: begin
                node_rd      = (r_head_q != NIL);
                node_rd_addr = r_head_q;
            end
            ST_NODE: begin
                node_rd = !key_hit && (r_link_q != NIL);
            end
            ST_EXEC: begin
                if (r_op == OP_INSERT && found) begin
                    val_we = 1'b1;
                end else if (r_op == OP_INSERT && r_free_head != NIL) begin
                    node_rd      = 1'b1;
                    node_rd_addr = r_free_head;
                end else if (r_op == OP_REMOVE && found) begin
                    // Unlink from the predecessor or from the bucket head.
                    link_we = (r_prev != NIL);
                    head_we = (r_prev == NIL);
                end
            end
            ST_ALLOC: begin
                key_we  = 1'b1;
                val_we  = 1'b1;
                kv_wa   = r_free_head;
                link_we = 1'b1;
                link_wa = r_free_head;
                link_wd = r_head;
                head_we = 1'b1;
                head_wd = r_free_head;
            end
            ST_FREE: begin
                link_we = 1'b1;
                link_wa = r_cur;
                link_wd = r_free_head;
            end
            default: ;
        endcase
    end

    // Bucket head memory.
    always_ff @(posedge i_clk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        if (head_rd) r_head_q <= head_mem[head_rd_addr];
    end

    // Node memories share one read address.
    always_ff @(posedge i_clk) begin
        if (link_we) link_mem[link_wa[NODE_W-1:0]] <= link_wd;
        if (key_we)  key_mem[kv_wa[NODE_W-1:0]]    <= r_key;
        if (val_we)  val_mem[kv_wa[NODE_W-1:0]]    <= val_wd;
        if (node_rd) begin
            r_link_q <= link_mem[node_rd_addr[NODE_W-1:0]];
            r_key_q  <= key_mem[node_rd_addr[NODE_W-1:0]];
            r_val_q  <= val_mem[node_rd_addr[NODE_W-1:0]];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_sweep     <= '0;
            r_init_done <= 1'b0;
            r_free_head <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_INIT) begin
                r_sweep <= r_sweep + SW_W'(1);
                if (sweep_end) r_init_done <= 1'b1;
            end
            if (r_state == ST_ALLOC) begin
                r_free_head <= r_link_q;
                r_count     <= r_count + PTR_W'(1);
            end
            if (r_state == ST_FREE) begin
                r_free_head <= r_cur;
                if (r_count != '0) r_count <= r_count - PTR_W'(1);
            end
            if (out_load) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    // Request capture, chain walk and result forming.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_op  <= i_q_op;
            r_key <= i_q_key;
            r_val <= i_q_val;
            r_bkt <= i_q_bkt;
        end
        if (r_state == ST_HEAD) begin
            r_head <= r_head_q;
            r_cur  <= r_head_q;
            r_prev <= NIL;
        end
        if (r_state == ST_NODE) begin
            if (key_hit) begin
                r_fval  <= r_val_q;
                r_flink <= r_link_q;
            end else begin
                r_prev <= r_cur;
                r_cur  <= r_link_q;
            end
        end
        if (r_state == ST_EXEC) begin
            r_res_value  <= '0;
            r_res_status <= STAT_OK;
            if (!found && r_op != OP_INSERT) begin
                r_res_status <= STAT_MISS;
            end else if (!found && r_free_head == NIL) begin
                r_res_status <= STAT_FULL;
            end else if (found && r_op != OP_INSERT) begin
                r_res_value <= r_fval;
            end
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= DATA_W'(r_res_value);
            r_out_count  <= r_count;
        end
    end

    assign o_back.pop       = pop;
    assign o_back.init_done = r_init_done;
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_value_out      = r_out_value;
    assign o_entry_count    = r_out_count;

    // The entry count never passes the pool size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("entry count above pool size");

    // The entry count moves by at most one per cycle.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_init_done && $past(r_init_done)) |->
        (r_count == $past(r_count) || r_count == $past(r_count) + PTR_W'(1) ||
         r_count == $past(r_count) - PTR_W'(1)))
        else $error("entry count jumped");

    // Requests leave the queue only when the sequencer is idle and ready.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_state == ST_IDLE && r_init_done))
        else $error("request popped while busy");

    // A full status is only given with an empty free list.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_res_status == STAT_FULL) |-> (r_free_head == NIL))
        else $error("pool full reported with free nodes");

    // A node allocation only happens with a free node available.
    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALLOC) |-> (r_free_head != NIL && r_count < NIL))
        else $error("allocation from empty pool");

endmodule

@@ rtl/chained_int_key_hash_map_top.sv @@
// Top level of the chained integer-key hash map: configuration register,
// front end request queue and back end table. Depends on hmap_pkg,
// hmap_front and hmap_back.
//
//   Channel  Direction  Handshake             Word
//   input    in         i_valid / o_ready     i_operation, i_key, i_value_in
//   result   out        o_valid / i_ready     o_status, o_value_out, o_entry_count
//   config   in         i_cfg_valid / o_cfg_ready  i_cfg_data (bucket_count_log2)
//
// An operation occupies the back end in its IDLE, HEAD, EXEC and RESULT states,
// a NODE state per chain node visited, and an ALLOC state for an insert of a new key
// into a non-full pool or a FREE state for a remove that finds its key; the single
// read port of the node memories, one node per read, sets this pace. A clearing pass
// over max(MAX_BUCKETS, NODE_POOL) addresses (1024 at defaults) runs after reset,
// and no word is taken until it ends. A result that waits on i_ready holds the
// back end; a two-word queue lets input words be taken meanwhile until it fills.
module chained_int_key_hash_map_top #(
    parameter int MAX_BUCKETS = 256,
    parameter int NODE_POOL   = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [hmap_pkg::OP_W-1:0]         i_operation,
    input  logic signed [hmap_pkg::KEY_W-1:0] i_key,
    input  logic [hmap_pkg::DATA_W-1:0]       i_value_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [hmap_pkg::STAT_W-1:0]       o_status,
    output logic [hmap_pkg::DATA_W-1:0]       o_value_out,
    output logic [$clog2(NODE_POOL):0]        o_entry_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hmap_pkg::CFG_W-1:0]        i_cfg_data
);
    import hmap_pkg::*;

    localparam int BKT_W = $clog2(MAX_BUCKETS);
    localparam int PTR_W = $clog2(NODE_POOL) + 1;
    localparam int VW    = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

    logic [CFG_W-1:0] r_log2;
    t_back_ctl        back_ctl;
    logic             q_valid;
    t_op              q_op;
    logic [KEY_W-1:0] q_key;
    logic [VW-1:0]    q_val;
    logic [BKT_W-1:0] q_bkt;

    // Bucket count register; always writable.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2 <= MIN_LOG2;
        end else if (i_cfg_valid) begin
            r_log2 <= i_cfg_data;
        end
    end

    hmap_front #(
        .BKT_W (BKT_W),
        .VW    (VW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_value_in  (i_value_in[VW-1:0]),
        .i_log2      (r_log2),
        .i_back      (back_ctl),
        .o_q_valid   (q_valid),
        .o_q_op      (q_op),
        .o_q_key     (q_key),
        .o_q_val     (q_val),
        .o_q_bkt     (q_bkt)
    );

    hmap_back #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .NODE_POOL   (NODE_POOL),
        .BKT_W       (BKT_W),
        .PTR_W       (PTR_W),
        .VW          (VW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_op        (q_op),
        .i_q_key       (q_key),
        .i_q_val       (q_val),
        .i_q_bkt       (q_bkt),
        .o_back        (back_ctl),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_value_out   (o_value_out),
        .o_entry_count (o_entry_count)
    );

endmodule

@@ tb/hmap_checker.sv @@
// Checker for the chained integer-key hash map: watches the input, result and
// configuration channels, predicts each result word and compares it.
// Depends on hmap_pkg.
`timescale 1ns / 1ps

module hmap_checker #(
    parameter int MAX_BUCKETS = 256,
    parameter int NODE_POOL   = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_ready_in,
    input  logic [hmap_pkg::OP_W-1:0]         i_operation,
    input  logic [hmap_pkg::KEY_W-1:0]        i_key,
    input  logic [hmap_pkg::DATA_W-1:0]       i_value_in,
    input  logic                              i_res_valid,
    input  logic                              i_res_ready,
    input  logic [hmap_pkg::STAT_W-1:0]       i_status,
    input  logic [hmap_pkg::DATA_W-1:0]       i_value_out,
    input  logic [$clog2(NODE_POOL):0]        i_entry_count,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [hmap_pkg::CFG_W-1:0]        i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);
    import hmap_pkg::*;

    localparam int CW = $clog2(NODE_POOL) + 1;
    localparam logic [CW-1:0] NIL = CW'(NODE_POOL);

    typedef struct packed {
        t_status          status;
        logic [DATA_W-1:0] value;
        logic [CW-1:0]    count;
    } t_result;

    // Shadow copy of the table.
    logic [CFG_W-1:0]  log2_sh;
    logic [CW-1:0]     head_sh [MAX_BUCKETS];
    logic [KEY_W-1:0]  key_sh  [NODE_POOL];
    logic [DATA_W-1:0] val_sh  [NODE_POOL];
    logic [CW-1:0]     link_sh [NODE_POOL];
    logic [CW-1:0]     free_sh;
    logic [CW-1:0]     held_sh;
    t_result           results_due[$];

    function automatic int bucket_index(logic [KEY_W-1:0] k);
        int lg;
        lg = (log2_sh < MIN_LOG2) ? int'(MIN_LOG2) : int'(log2_sh);
        return int'(k & ((32'd1 << lg) - 1) & (MAX_BUCKETS - 1));
    endfunction

    // Apply one operation to the shadow table and return the expected word.
    function automatic t_result apply_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                         logic [DATA_W-1:0] v);
        t_result r;
        int b;
        logic [CW-1:0] n, p, f;
        int steps;
        b = bucket_index(k);
        n = head_sh[b];
        p = NIL;
        steps = 0;
        while (n < NIL && steps < NODE_POOL && key_sh[n] != k) begin
            p = n;
            n = link_sh[n];
            steps++;
        end
        if (steps >= NODE_POOL) n = NIL;
        r.status = STAT_OK;
        r.value = '0;
        if (op == OPC_INSERT) begin
            if (n < NIL) begin
                val_sh[n] = v;
            end else if (free_sh >= NIL) begin
                r.status = STAT_FULL;
            end else begin
                f = free_sh;
                free_sh = link_sh[f];
                key_sh[f] = k;
                val_sh[f] = v;
                link_sh[f] = head_sh[b];
                head_sh[b] = f;
                held_sh++;
            end
        end else if (op == OPC_REMOVE) begin
            if (n < NIL) begin
                if (p < NIL) link_sh[p] = link_sh[n];
                else head_sh[b] = link_sh[n];
                r.value = val_sh[n];
                link_sh[n] = free_sh;
                free_sh = n;
                if (held_sh > 0) held_sh--;
            end else begin
                r.status = STAT_MISS;
            end
        end else begin
            if (n < NIL) r.value = val_sh[n];
            else r.status = STAT_MISS;
        end
        r.count = held_sh;
        return r;
    endfunction

    assign o_pending = results_due.size();

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            log2_sh <= MIN_LOG2;
            for (int i = 0; i < MAX_BUCKETS; i++) head_sh[i] = NIL;
            for (int i = 0; i < NODE_POOL; i++) link_sh[i] = CW'(i + 1);
            free_sh = '0;
            held_sh = '0;
            results_due.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) log2_sh <= i_cfg_data;
            if (i_valid && i_ready_in)
                results_due.push_back(apply_op(i_operation, i_key, i_value_in));
            if (i_res_valid && i_res_ready) begin
                if (results_due.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("Unexpected result word: status %0d value %h count %0d",
                                 i_status, i_value_out, i_entry_count);
                end else begin
                    exp_r = results_due.pop_front();
                    if (exp_r.status != i_status || exp_r.value != i_value_out
                            || exp_r.count != i_entry_count) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display({"Mismatch: expected status %0d value %h count %0d,",
                                      " got status %0d value %h count %0d"},
                                     exp_r.status, exp_r.value, exp_r.count,
                                     i_status, i_value_out, i_entry_count);
                    end
                end
            end
        end
    end
endmodule

@@ tb/tb.sv @@
// Stimulus and verdict for the chained integer-key hash map.
// Depends on hmap_pkg, chained_int_key_hash_map_top and hmap_checker.
`timescale 1ns / 1ps

module tb;
    import hmap_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  in_op;
    logic [31:0] in_key;
    logic [31:0] in_val;
    logic        res_valid;
    logic        res_ready;
    logic [1:0]  res_status;
    logic [31:0] res_value;
    logic [10:0] res_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    int          errors;
    int          pending;
    logic        hold_off;
    logic [31:0] key_pool[$];

    chained_int_key_hash_map_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_operation(in_op), .i_key(in_key), .i_value_in(in_val),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_status(res_status), .o_value_out(res_value), .o_entry_count(res_count),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    hmap_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_ready_in(in_ready),
        .i_operation(in_op), .i_key(in_key), .i_value_in(in_val),
        .i_res_valid(res_valid), .i_res_ready(res_ready),
        .i_status(res_status), .i_value_out(res_value), .i_entry_count(res_count),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int g;
        res_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_off) begin
                res_ready <= 1'b0;
                repeat (60) @(posedge clk);
            end
            g = gap_length();
            if (g == 0 || $urandom_range(0, 3) == 0) begin
                res_ready <= 1'b1;
                @(posedge clk);
            end else begin
                res_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    // Send one word and wait for it to be taken; valid stays up for the caller.
    task automatic send_word(logic [1:0] op, logic [31:0] k, logic [31:0] v);
        in_valid <= 1'b1;
        in_op    <= op;
        in_key   <= k;
        in_val   <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_paced(logic [1:0] op, logic [31:0] k, logic [31:0] v);
        int g;
        send_word(op, k, v);
        g = gap_length();
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Write the bucket count log2 once every result has come back.
    task automatic write_log2(logic [3:0] lg);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lg;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom();
    endfunction

    // One random phase; keys drawn from a small pool so chains get long.
    task automatic random_phase(int count, int ins_weight);
        logic [1:0] op;
        logic [31:0] k;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < ins_weight) op = OPC_INSERT;
            else if (r < ins_weight + 25) op = OPC_REMOVE;
            else if (r < 98) op = OPC_FIND;
            else op = OPC_SPARE;
            k = pick_key();
            if (op == OPC_INSERT && key_pool.size() < 400) key_pool.push_back(k);
            send_paced(op, k, $urandom());
        end
    endtask

    initial begin
        int wait_cycles;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_op     = '0;
        in_key    = '0;
        in_val    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        hold_off  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every operation, reinsert of zero value.
        send_paced(OPC_FIND, 32'h0000_0000, 32'h0);
        send_paced(OPC_REMOVE, 32'h8000_0000, 32'h0);
        send_paced(OPC_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_paced(OPC_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
        send_paced(OPC_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
        send_paced(OPC_INSERT, 32'h0000_0000, 32'hA5A5_5A5A);
        send_paced(OPC_INSERT, 32'h0000_0008, 32'h0000_0001);
        send_paced(OPC_INSERT, 32'h0000_0010, 32'h0000_0002);
        send_paced(OPC_FIND, 32'h0000_0000, 32'h0);
        send_paced(OPC_FIND, 32'h0000_0010, 32'h0);
        send_paced(OPC_INSERT, 32'h7FFF_FFFF, 32'h0000_0055);
        send_paced(OPC_INSERT, 32'h0000_0008, 32'h0000_0000);
        send_paced(OPC_INSERT, 32'h0000_0008, 32'hFFFF_FFFF);
        send_paced(OPC_SPARE, 32'h0000_0008, 32'h0);
        send_paced(OPC_SPARE, 32'h1111_1111, 32'h0);
        send_paced(OPC_REMOVE, 32'h0000_0008, 32'h0);
        send_paced(OPC_REMOVE, 32'h0000_0008, 32'h0);
        send_paced(OPC_FIND, 32'h8000_0000, 32'h0);
        send_paced(OPC_REMOVE, 32'h0000_0010, 32'h0);

        // Low setting acts as three; entries left in place are not rehashed.
        write_log2(4'd0);
        send_paced(OPC_FIND, 32'hFFFF_FFFF, 32'h0);
        send_paced(OPC_FIND, 32'h0000_0000, 32'h0);
        random_phase(60, 45);

        // Long result hold-off so the input side fills and stalls.
        hold_off <= 1'b1;
        for (int i = 0; i < 12; i++) send_word(OPC_FIND, pick_key(), 32'h0);
        hold_off <= 1'b0;

        write_log2(4'd8);
        send_paced(OPC_FIND, 32'hFFFF_FFFF, 32'h0);
        random_phase(50, 40);
        write_log2(4'd15);
        random_phase(40, 40);
        write_log2(4'd5);
        random_phase(40, 35);

        // Fill the pool to see a full status, then run random phases with a fresh key pool.
        write_log2(4'd3);
        for (int i = 0; i < 1030; i++) send_word(OPC_INSERT, $urandom(), $urandom());
        send_paced(OPC_INSERT, 32'h5555_AAAA, 32'h1);
        key_pool.delete();
        write_log2(4'd7);
        random_phase(50, 30);
        write_log2(4'd3);
        random_phase(50, 30);
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (1200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end
endmodule

@@ chained_int_key_hash_map_top.f @@
rtl/hmap_pkg.sv
rtl/hmap_front.sv
rtl/hmap_back.sv
rtl/chained_int_key_hash_map_top.sv
tb/hmap_checker.sv
tb/tb.sv
